// File: hw/rtl/sha1_byte_stream_hasher_defines.svh
// Assertion macros used by the SHA-1 byte stream hasher core (sbsh_core).
// Needs a clk and rst in the scope of each use.
`ifndef SHA1_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA1_BYTE_STREAM_HASHER_DEFINES_SVH

// same-cycle implication
`define SBSH_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sbsh check failed");

// next-cycle implication
`define SBSH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sbsh check failed");

`endif

// File: hw/rtl/sbsh_pkg.sv
// Shared types, constants and helpers for the SHA-1 byte stream hasher.
// No dependencies.
package sbsh_pkg;

  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_FINISH  = 2'd1,
    OP_RESTART = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_t;

  localparam logic [31:0] H_INIT_0 = 32'h67452301;
  localparam logic [31:0] H_INIT_1 = 32'hEFCDAB89;
  localparam logic [31:0] H_INIT_2 = 32'h98BADCFE;
  localparam logic [31:0] H_INIT_3 = 32'h10325476;
  localparam logic [31:0] H_INIT_4 = 32'hC3D2E1F0;

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [5:0] LAST_SLOT  = 6'd63;
  localparam logic [5:0] LEN_SLOT   = 6'd56;
  localparam logic [3:0] LEN_BYTES  = 4'd8;

  function automatic logic [31:0] round_k(input logic [6:0] rnd);
    logic [31:0] k;
    if (rnd < 7'd20)      k = 32'h5A827999;
    else if (rnd < 7'd40) k = 32'h6ED9EBA1;
    else if (rnd < 7'd60) k = 32'h8F1BBCDC;
    else                  k = 32'hCA62C1D6;
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (rnd < 7'd20)      f = (b & c) | (~b & d);
    else if (rnd < 7'd40) f = b ^ c ^ d;
    else if (rnd < 7'd60) f = (b & c) | (b & d) | (c & d);
    else                  f = b ^ c ^ d;
    return f;
  endfunction

endpackage

// File: hw/rtl/sbsh_front.sv
// Front end: takes stream words, decodes the command, queues work for the core.
// Depends on sbsh_pkg.
module sbsh_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,  // [7:0] data_byte
  input  logic [1:0]           s_axis_tuser,  // [1:0] cmd
  output logic                 q_valid,
  output sbsh_pkg::item_t      q_item,
  input  logic                 q_pop
);

  sbsh_pkg::item_t slot [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            push;
  logic            take;
  sbsh_pkg::op_t   op;

  assign s_axis_tready = (count != 2'd2);
  assign op            = sbsh_pkg::op_t'(s_axis_tuser);
  assign take          = s_axis_tvalid && s_axis_tready;
  // unused command code is swallowed here
  assign push          = take && (op != sbsh_pkg::OP_NONE);
  assign q_valid       = (count != 2'd0);
  assign q_item        = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= '{op: op, data: s_axis_tdata};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// File: hw/rtl/sbsh_core.sv
// Back end: absorbs bytes, pads, runs the 80 SHA-1 rounds, holds the result register.
// Depends on sbsh_pkg and sha1_byte_stream_hasher_defines.svh.
`include "sha1_byte_stream_hasher_defines.svh"

module sbsh_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  sbsh_pkg::item_t q_item,
  output logic            q_pop,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [159:0]    m_axis_tdata,  // [31:0] digest_word_0 .. [159:128] digest_word_4
  output logic [0:0]      m_axis_tuser   // [0] ok
);

  sbsh_pkg::state_t state, state_next;

  logic [31:0]  hash [5];
  logic [511:0] blk;          // byte window, oldest byte on top
  logic [5:0]   fill;
  logic [63:0]  bit_length;
  logic         finished;
  logic         corrupt;
  logic         padding;
  logic         pad_first;
  logic [3:0]   len_cnt;
  logic [6:0]   rnd;
  logic [31:0]  a, b, c, d, e;

  logic         out_free;
  logic         load_out;
  logic [63:0]  len_sum;
  logic [7:0]   pad_byte;
  logic         len_phase;
  logic [31:0]  w0, w2, w8, w13, w_mix, w_new, t_sum;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign len_sum  = bit_length + 64'd8;
  assign len_phase = (len_cnt != 4'd0) || (fill == sbsh_pkg::LEN_SLOT);

  always_comb begin
    if (pad_first)      pad_byte = sbsh_pkg::PAD_MARK;
    else if (len_phase) pad_byte = bit_length[6'(8 * (7 - int'(len_cnt[2:0]))) +: 8];
    else                pad_byte = 8'h00;
  end

  // message schedule from fixed taps of the window
  assign w0    = blk[511 -: 32];
  assign w2    = blk[447 -: 32];
  assign w8    = blk[255 -: 32];
  assign w13   = blk[95 -: 32];
  assign w_mix = w13 ^ w8 ^ w2 ^ w0;
  assign w_new = {w_mix[30:0], w_mix[31]};
  assign t_sum = {a[26:0], a[31:27]} + sbsh_pkg::round_f(rnd, b, c, d) + e + w0
               + sbsh_pkg::round_k(rnd);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      sbsh_pkg::ST_IDLE: begin
        if (q_valid) begin
          unique case (q_item.op)
            sbsh_pkg::OP_BYTE: begin
              if (!finished && !corrupt && fill == sbsh_pkg::LAST_SLOT)
                state_next = sbsh_pkg::ST_ROUND;
            end
            sbsh_pkg::OP_FINISH: begin
              state_next = (corrupt || finished) ? sbsh_pkg::ST_EMIT : sbsh_pkg::ST_PAD;
            end
            default: state_next = sbsh_pkg::ST_IDLE;
          endcase
        end
      end
      sbsh_pkg::ST_PAD: begin
        if (fill == sbsh_pkg::LAST_SLOT) state_next = sbsh_pkg::ST_ROUND;
      end
      sbsh_pkg::ST_ROUND: begin
        if (rnd == sbsh_pkg::LAST_ROUND) state_next = sbsh_pkg::ST_ADD;
      end
      sbsh_pkg::ST_ADD: begin
        if (padding && len_cnt == sbsh_pkg::LEN_BYTES) state_next = sbsh_pkg::ST_EMIT;
        else if (padding)                               state_next = sbsh_pkg::ST_PAD;
        else                                            state_next = sbsh_pkg::ST_IDLE;
      end
      sbsh_pkg::ST_EMIT: begin
        if (out_free) state_next = sbsh_pkg::ST_IDLE;
      end
      default: state_next = sbsh_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop    = 1'b0;
    load_out = 1'b0;
    unique case (state)
      sbsh_pkg::ST_IDLE: q_pop    = q_valid;
      sbsh_pkg::ST_EMIT: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= sbsh_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // round registers, loaded on entry to the round loop
  always_ff @(posedge clk) begin
    if (state_next == sbsh_pkg::ST_ROUND && state != sbsh_pkg::ST_ROUND) begin
      a   <= hash[0];
      b   <= hash[1];
      c   <= hash[2];
      d   <= hash[3];
      e   <= hash[4];
      rnd <= '0;
    end else if (state == sbsh_pkg::ST_ROUND) begin
      a   <= t_sum;
      b   <= a;
      c   <= {b[1:0], b[31:2]};
      d   <= c;
      e   <= d;
      rnd <= rnd + 7'd1;
    end
  end

  // byte window
  always_ff @(posedge clk) begin
    if (state == sbsh_pkg::ST_IDLE && q_valid && q_item.op == sbsh_pkg::OP_BYTE &&
        !finished && !corrupt) begin
      blk <= {blk[503:0], q_item.data};
    end else if (state == sbsh_pkg::ST_PAD) begin
      blk <= {blk[503:0], pad_byte};
    end else if (state == sbsh_pkg::ST_ROUND) begin
      blk <= {blk[479:0], w_new};
    end
  end

  // chaining and message state
  always_ff @(posedge clk) begin
    if (rst) begin
      hash       <= '{sbsh_pkg::H_INIT_0, sbsh_pkg::H_INIT_1, sbsh_pkg::H_INIT_2,
                      sbsh_pkg::H_INIT_3, sbsh_pkg::H_INIT_4};
      fill       <= '0;
      bit_length <= '0;
      finished   <= 1'b0;
      corrupt    <= 1'b0;
      padding    <= 1'b0;
      pad_first  <= 1'b0;
      len_cnt    <= '0;
    end else begin
      unique case (state)
        sbsh_pkg::ST_IDLE: begin
          if (q_valid) begin
            unique case (q_item.op)
              sbsh_pkg::OP_BYTE: begin
                if (finished || corrupt) begin
                  corrupt <= 1'b1;
                end else begin
                  fill       <= fill + 6'd1;
                  bit_length <= len_sum;
                  if (len_sum == 64'd0) corrupt <= 1'b1;
                end
              end
              sbsh_pkg::OP_FINISH: begin
                if (!corrupt && !finished) begin
                  padding   <= 1'b1;
                  pad_first <= 1'b1;
                  len_cnt   <= '0;
                end
              end
              sbsh_pkg::OP_RESTART: begin
                hash       <= '{sbsh_pkg::H_INIT_0, sbsh_pkg::H_INIT_1, sbsh_pkg::H_INIT_2,
                                sbsh_pkg::H_INIT_3, sbsh_pkg::H_INIT_4};
                fill       <= '0;
                bit_length <= '0;
                finished   <= 1'b0;
                corrupt    <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        sbsh_pkg::ST_PAD: begin
          fill      <= fill + 6'd1;
          pad_first <= 1'b0;
          if (!pad_first && len_phase) len_cnt <= len_cnt + 4'd1;
        end
        sbsh_pkg::ST_ADD: begin
          hash[0] <= hash[0] + a;
          hash[1] <= hash[1] + b;
          hash[2] <= hash[2] + c;
          hash[3] <= hash[3] + d;
          hash[4] <= hash[4] + e;
          if (padding && len_cnt == sbsh_pkg::LEN_BYTES) begin
            padding  <= 1'b0;
            finished <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tuser <= ~corrupt;
      m_axis_tdata <= corrupt ? '0 : {hash[4], hash[3], hash[2], hash[1], hash[0]};
    end
  end

  `SBSH_ASSERT_NOW(a_round_range, state == sbsh_pkg::ST_ROUND, rnd <= sbsh_pkg::LAST_ROUND)
  `SBSH_ASSERT_NOW(a_pad_clean, state == sbsh_pkg::ST_PAD, padding && !corrupt && !finished)
  `SBSH_ASSERT_NEXT(a_bad_zero, load_out && corrupt, m_axis_tvalid && m_axis_tdata == 160'd0)

endmodule

// File: hw/rtl/sha1_byte_stream_hasher.sv
// Top level of the SHA-1 byte stream hasher.
// Depends on sbsh_pkg, sbsh_front and sbsh_core.
//
// One word in is one command: tuser carries cmd (0 absorb tdata as a message byte,
// 1 finish and return the digest, 2 restart, 3 ignored). Only finish returns a word:
// tuser[0] is ok, tdata holds H0..H4 with H0 in the low 32 bits, all zero when ok is 0.
// A byte after finish, or a 64-bit length overflow, marks the hash corrupt until
// restart; a second finish returns the same digest again. A two-word queue sits
// between the input decode and the hash core, and the digest sits in its own output
// register, so the core goes on taking words while a result waits; once a further
// digest is ready it stalls and the queue takes up to two more. The core absorbs one
// byte per cycle, but stalls while a full 64-byte block runs its 80 rounds and the
// chaining add. Finish pads one byte a cycle and runs one or two blocks before the
// digest shows.
module sha1_byte_stream_hasher (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]   s_axis_tuser,   // [1:0] cmd
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [159:0] m_axis_tdata,   // [31:0] digest_word_0 .. [159:128] digest_word_4
  output logic [0:0]   m_axis_tuser    // [0] ok
);

  logic            q_valid;
  logic            q_pop;
  sbsh_pkg::item_t q_item;

  sbsh_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  sbsh_core u_core (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// File: test/tb.sv
// Self-checking testbench for the SHA-1 byte stream hasher.
// Depends on sbsh_pkg and the sha1_byte_stream_hasher RTL.
// A behavioral SHA-1 in the scoreboard predicts each digest word.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic         ok;
    logic [159:0] digest;
  } digest_t;

  // Scoreboard: keeps a running SHA-1 state and a queue of expected digests.
  class sha1_scoreboard;
    logic [31:0] hw[5];
    logic [7:0]  blk[64];
    int          fill;
    logic [63:0] nbits;
    bit          done_pad, bad;
    digest_t     pending[$];
    int          errors;
    int          digests_seen;

    function void restart();
      hw[0] = 32'h67452301; hw[1] = 32'hEFCDAB89; hw[2] = 32'h98BADCFE;
      hw[3] = 32'h10325476; hw[4] = 32'hC3D2E1F0;
      fill = 0; nbits = '0; done_pad = 0; bad = 0;
    endfunction

    function new();
      errors = 0;
      digests_seen = 0;
      restart();
    endfunction

    function logic [31:0] rol(logic [31:0] x, int n);
      return (x << n) | (x >> (32 - n));
    endfunction

    function void compress();
      logic [31:0] w[80];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int i = 0; i < 16; i++)
        w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      for (int i = 16; i < 80; i++)
        w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
      a = hw[0]; b = hw[1]; c = hw[2]; d = hw[3]; e = hw[4];
      for (int i = 0; i < 80; i++) begin
        if (i < 20) begin
          f = (b & c) | (~b & d); k = 32'h5A827999;
        end else if (i < 40) begin
          f = b ^ c ^ d; k = 32'h6ED9EBA1;
        end else if (i < 60) begin
          f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
        end else begin
          f = b ^ c ^ d; k = 32'hCA62C1D6;
        end
        t = rol(a, 5) + f + e + w[i] + k;
        e = d; d = c; c = rol(b, 30); b = a; a = t;
      end
      hw[0] += a; hw[1] += b; hw[2] += c; hw[3] += d; hw[4] += e;
      fill = 0;
    endfunction

    // Note one accepted input word.
    function void note_input(sbsh_pkg::op_t op, logic [7:0] data);
      digest_t r;
      case (op)
        sbsh_pkg::OP_BYTE: begin
          if (done_pad || bad) begin
            bad = 1;
          end else begin
            blk[fill] = data;
            fill++;
            nbits += 64'd8;
            if (nbits == '0) bad = 1;
            if (fill == 64) compress();
          end
        end
        sbsh_pkg::OP_FINISH: begin
          if (bad) begin
            r.ok = 0; r.digest = '0;
          end else begin
            if (!done_pad) begin
              blk[fill] = 8'h80; fill++;
              if (fill > 56) begin
                while (fill < 64) begin blk[fill] = 0; fill++; end
                compress();
              end
              while (fill < 56) begin blk[fill] = 0; fill++; end
              for (int i = 0; i < 8; i++) blk[56+i] = nbits[63-8*i -: 8];
              compress();
              done_pad = 1;
            end
            r.ok = 1;
            r.digest = {hw[4], hw[3], hw[2], hw[1], hw[0]};
          end
          pending.push_back(r);
        end
        sbsh_pkg::OP_RESTART: restart();
        default: ;
      endcase
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    // Check one accepted output word against the oldest expectation.
    task check_digest(logic ok, logic [159:0] dig);
      digest_t r;
      digests_seen++;
      if (pending.size() == 0) begin
        report("digest with nothing expected");
        return;
      end
      r = pending.pop_front();
      if (ok !== r.ok) report($sformatf("ok got %0b want %0b", ok, r.ok));
      for (int i = 0; i < 5; i++)
        if (dig[32*i +: 32] !== r.digest[32*i +: 32])
          report($sformatf("digest_word_%0d got %h want %h", i, dig[32*i +: 32],
                           r.digest[32*i +: 32]));
    endtask
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = sbsh_pkg::OP_NONE;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [159:0] m_axis_tdata;
  logic [0:0]   m_axis_tuser;

  sha1_byte_stream_hasher i_dut (.*);

  sha1_scoreboard sb = new();
  int  send_idle_pct = 0;   // chance in percent of an idle cycle on the sender
  int  recv_stall_pct = 0;  // chance of a stalled receiver cycle
  int  n_words = 0;
  longint cycles = 0;
  localparam longint CYCLE_LIMIT = 2_000_000;

  initial forever #5 clk = ~clk;

  // Cycle limit guards against a hung handshake.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: random tready, check on each accepted digest word.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_digest(m_axis_tuser[0], m_axis_tdata);
  end
  always @(negedge clk) begin
    m_axis_tready <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  // Drive one word; it is noted by the scoreboard when the handshake completes.
  // tvalid stays high after the word so back-to-back words need no gap.
  task send_word(sbsh_pkg::op_t op, logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= data;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(op, data);
    n_words++;
    @(negedge clk);
  endtask

  task send_message(int len);
    for (int i = 0; i < len; i++) send_word(sbsh_pkg::OP_BYTE, 8'($urandom));
  endtask

  // Random sequences: mostly well-formed restart/message/finish runs.
  task random_run(int budget);
    int used, len, pick;
    used = 0;
    while (used < budget) begin
      pick = $urandom_range(9);
      len = ($urandom_range(3) == 0) ? $urandom_range(130) : $urandom_range(70);
      if (pick < 7) begin
        send_word(sbsh_pkg::OP_RESTART, 8'($urandom));
        send_message(len);
        send_word(sbsh_pkg::OP_FINISH, 8'($urandom));
        if ($urandom_range(3) == 0) send_word(sbsh_pkg::OP_FINISH, 8'($urandom));
        used += len + 2;
      end else begin
        // noise: unused code, stray bytes after finish, random commands
        for (int i = 0; i < 8; i++)
          send_word(sbsh_pkg::op_t'($urandom_range(3)), 8'($urandom));
        used += 8;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: empty message, data extremes, padding boundaries around 55/56/64 bytes.
    send_word(sbsh_pkg::OP_FINISH, 8'h00);
    send_word(sbsh_pkg::OP_FINISH, 8'hFF);       // repeated finish returns same digest
    send_word(sbsh_pkg::OP_RESTART, 8'h00);
    send_word(sbsh_pkg::OP_BYTE, 8'h00);
    send_word(sbsh_pkg::OP_BYTE, 8'hFF);
    send_word(sbsh_pkg::OP_BYTE, 8'hA5);
    send_word(sbsh_pkg::OP_NONE, 8'h5A);         // unused code ignored
    send_word(sbsh_pkg::OP_FINISH, 8'h00);
    send_word(sbsh_pkg::OP_BYTE, 8'h11);         // byte after finish corrupts
    send_word(sbsh_pkg::OP_FINISH, 8'h00);       // ok=0, zero digest
    send_word(sbsh_pkg::OP_BYTE, 8'h22);         // ignored while corrupt
    send_word(sbsh_pkg::OP_FINISH, 8'h00);
    send_word(sbsh_pkg::OP_RESTART, 8'hFF);
    send_message(55);
    send_word(sbsh_pkg::OP_FINISH, 8'h00);
    send_word(sbsh_pkg::OP_RESTART, 8'h00);
    send_message(56);                  // padding spills into a second block
    send_word(sbsh_pkg::OP_FINISH, 8'h00);
    send_word(sbsh_pkg::OP_RESTART, 8'h00);
    send_message(64);
    send_word(sbsh_pkg::OP_FINISH, 8'h00);

    // Random phases, with and without sender idling and receiver stalls.
    send_idle_pct = 0;  recv_stall_pct = 0;  random_run(400);
    send_idle_pct = 50; recv_stall_pct = 0;  random_run(400);
    send_idle_pct = 0;  recv_stall_pct = 50; random_run(400);
    send_idle_pct = 17; recv_stall_pct = 17; random_run(400);
    s_axis_tvalid <= 0;

    // Drain, then allow for the longest finish latency.
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("covered %0d input words and %0d digests, with and without back-pressure",
             n_words, sb.digests_seen);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
